[rtl/dbrc_pkg.sv]
// ----------------------------------------------------------------------------
// dbrc_pkg
// Types and constants shared by the blink rate controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dbrc_pkg;

   localparam int DEB_W      = 10;
   localparam int RATE_W     = 8;
   localparam int MV_W       = 12;
   localparam int HALF_W     = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int STEP_W     = 4;

   // one quotient bit per divider step
   localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(HALF_W - 1);

   localparam logic [DEB_W-1:0]  DEBOUNCE_RESET  = 10'd50;
   localparam logic [RATE_W-1:0] DEFAULT_RESET   = 8'd10;
   localparam logic [RATE_W-1:0] MAX_RESET       = 8'd50;
   localparam logic [RATE_W-1:0] STEP_RESET      = 8'd1;
   localparam logic [MV_W-1:0]   THRESHOLD_RESET = 12'd2500;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic div_done;
      logic load_out;
   } dbrc_cmd_type;

   typedef struct packed {
      logic count_zero;
   } dbrc_sts_type;

endpackage

`default_nettype wire

[rtl/dbrc_ctrl.sv]
// ----------------------------------------------------------------------------
// dbrc_ctrl
// Sequencer: accepts a tick, runs the hold-time divider when the LED toggles,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dbrc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire dbrc_pkg::dbrc_sts_type sts,
   output dbrc_pkg::dbrc_cmd_type     cmd
);
   import dbrc_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.count_zero ? ST_DIVIDE : ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            if (step_ff == DIV_LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cmd.div_done = (step_ff == DIV_LAST_STEP);
         end
         ST_FINISH: begin
            cmd.load_out = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (cmd.accept) begin
         step_in = '0;
      end else if (cmd.div_step) begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[rtl/dbrc_datapath.sv]
// ----------------------------------------------------------------------------
// dbrc_datapath
// Debounce, rate and reset-latch state, LED timer, bit-serial hold divider,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dbrc_datapath #(
   parameter int HALF_SECOND_TICKS = 500
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dbrc_pkg::dbrc_cmd_type            cmd,
   output dbrc_pkg::dbrc_sts_type                 sts,
   input  wire logic                              csr_valid,
   input  wire logic [dbrc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dbrc_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                              req_button_sampled,
   input  wire logic                              req_button_pressed,
   input  wire logic                              req_reset_sampled,
   input  wire logic [dbrc_pkg::MV_W-1:0]         req_reset_mv,
   output logic                                   rsp_led_on,
   output logic [dbrc_pkg::RATE_W-1:0]            rsp_rate_hz,
   output logic                                   rsp_pressed_stable,
   output logic                                   rsp_rate_changed
);
   import dbrc_pkg::*;

   // configuration
   logic [DEB_W-1:0]  debounce_ff;
   logic [RATE_W-1:0] default_ff;
   logic [RATE_W-1:0] max_ff;
   logic [RATE_W-1:0] step_ff;
   logic [MV_W-1:0]   threshold_ff;

   // tick state
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic              led_ff, led_in;
   logic [HALF_W-1:0] half_count_ff, half_count_in;
   logic [DEB_W-1:0]  since_ff, since_in;
   logic              stable_ff, stable_in;
   logic              latch_ff, latch_in;
   logic              changed_ff, changed_in;

   // divider
   logic [HALF_W-1:0] div_q_ff, div_q_in;
   logic [RATE_W-1:0] div_r_ff, div_r_in;
   logic [HALF_W-1:0] rem_shift;
   logic [RATE_W-1:0] divisor;
   logic              div_ge;
   logic [HALF_W-1:0] rem_sub;
   logic [HALF_W-1:0] q_next;

   // result register
   logic              out_led_ff;
   logic [RATE_W-1:0] out_rate_ff;
   logic              out_stable_ff;
   logic              out_changed_ff;

   logic [DEB_W-1:0]  since_inc;
   logic              btn_take;
   logic [RATE_W:0]   rate_sum;
   logic [RATE_W:0]   rate_lo;
   logic [RATE_W-1:0] rate_press;
   logic [RATE_W-1:0] rate_default;

   assign sts.count_zero = (half_count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RESET;
         default_ff   <= DEFAULT_RESET;
         max_ff       <= MAX_RESET;
         step_ff      <= STEP_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE:  debounce_ff  <= csr_data[DEB_W-1:0];
            CSR_DEFAULT:   default_ff   <= csr_data[RATE_W-1:0];
            CSR_MAX:       max_ff       <= csr_data[RATE_W-1:0];
            CSR_STEP:      step_ff      <= csr_data[RATE_W-1:0];
            CSR_THRESHOLD: threshold_ff <= csr_data[MV_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp of a press and of a rate reset
   always_comb begin
      rate_sum = {1'b0, rate_ff} + {1'b0, step_ff};
      rate_lo  = (rate_sum < {1'b0, default_ff}) ? {1'b0, default_ff} : rate_sum;
      rate_press = (rate_lo > {1'b0, max_ff}) ? max_ff : rate_lo[RATE_W-1:0];
      rate_default = (default_ff > max_ff) ? max_ff : default_ff;
   end

   always_comb begin
      since_inc = (since_ff < debounce_ff) ? since_ff + DEB_W'(1) : since_ff;
      btn_take  = req_button_sampled && (req_button_pressed != stable_ff)
                  && (since_inc >= debounce_ff);

      since_in      = since_ff;
      stable_in     = stable_ff;
      rate_in       = rate_ff;
      latch_in      = latch_ff;
      changed_in    = changed_ff;
      led_in        = led_ff;
      half_count_in = half_count_ff;

      if (cmd.accept) begin
         changed_in = 1'b0;
         since_in   = since_inc;
         if (btn_take) begin
            stable_in = req_button_pressed;
            since_in  = '0;
            if (req_button_pressed) begin
               rate_in    = rate_press;
               changed_in = 1'b1;
            end
         end
         if (req_reset_sampled) begin
            if (req_reset_mv >= threshold_ff) begin
               if (!latch_ff) begin
                  rate_in    = rate_default;
                  latch_in   = 1'b1;
                  changed_in = 1'b1;
               end
            end else begin
               latch_in = 1'b0;
            end
         end
         if (sts.count_zero) begin
            led_in = !led_ff;
         end else begin
            half_count_in = half_count_ff - HALF_W'(1);
         end
      end else if (cmd.div_done) begin
         half_count_in = (q_next == '0) ? '0 : q_next - HALF_W'(1);
      end
   end

   // restoring divider, one quotient bit per cycle; a zero rate divides by one
   always_comb begin
      divisor   = (rate_ff == '0) ? RATE_W'(1) : rate_ff;
      rem_shift = {div_r_ff, div_q_ff[HALF_W-1]};
      div_ge    = (rem_shift >= {1'b0, divisor});
      rem_sub   = div_ge ? rem_shift - {1'b0, divisor} : rem_shift;
      q_next    = {div_q_ff[HALF_W-2:0], div_ge};

      div_q_in = div_q_ff;
      div_r_in = div_r_ff;
      if (cmd.accept) begin
         div_q_in = HALF_W'(HALF_SECOND_TICKS);
         div_r_in = '0;
      end else if (cmd.div_step) begin
         div_q_in = q_next;
         div_r_in = rem_sub[RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff       <= DEFAULT_RESET;
         led_ff        <= 1'b0;
         half_count_ff <= '0;
         since_ff      <= '0;
         stable_ff     <= 1'b0;
         latch_ff      <= 1'b0;
      end else begin
         rate_ff       <= rate_in;
         led_ff        <= led_in;
         half_count_ff <= half_count_in;
         since_ff      <= since_in;
         stable_ff     <= stable_in;
         latch_ff      <= latch_in;
      end
   end

   always_ff @(posedge clock) begin
      changed_ff <= changed_in;
      div_q_ff   <= div_q_in;
      div_r_ff   <= div_r_in;
      if (cmd.load_out) begin
         out_led_ff     <= led_ff;
         out_rate_ff    <= rate_ff;
         out_stable_ff  <= stable_ff;
         out_changed_ff <= changed_ff;
      end
   end

   assign rsp_led_on         = out_led_ff;
   assign rsp_rate_hz        = out_rate_ff;
   assign rsp_pressed_stable = out_stable_ff;
   assign rsp_rate_changed   = out_changed_ff;

endmodule

`default_nettype wire

[rtl/debounced_blink_rate_controller.sv]
// ----------------------------------------------------------------------------
// debounced_blink_rate_controller
// Debounced button raises an LED blink rate; a reset voltage restores it.
//
// Each req item is one millisecond tick with optional button and reset-voltage
// samples. Each tick gives exactly one rsp item: LED level, rate, debounced
// button state and a rate-changed flag.
// Configuration goes through the csr channel (always ready), index 0 to 4:
// debounce ticks, default rate, max rate, rate step, reset threshold.
// Write it only while no item is in flight.
// On a toggle tick the 9-step serial divider computes HALF_SECOND_TICKS /
// rate for the next hold time before the result is loaded into the output
// register; one item is worked on at a time.
// The result sits in an output register; if rsp_ready stays low the block
// takes one more item and then holds it until the waiting result is taken.
// Reset (synchronous) restores register defaults, rate 10, LED off and makes
// the first tick toggle the LED.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_blink_rate_controller #(
   parameter int HALF_SECOND_TICKS = 500
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [dbrc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dbrc_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_button_sampled,
   input  wire logic                              req_button_pressed,
   input  wire logic                              req_reset_sampled,
   input  wire logic [dbrc_pkg::MV_W-1:0]         req_reset_mv,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_led_on,
   output logic [dbrc_pkg::RATE_W-1:0]            rsp_rate_hz,
   output logic                                   rsp_pressed_stable,
   output logic                                   rsp_rate_changed
);
   import dbrc_pkg::*;

   dbrc_cmd_type cmd;
   dbrc_sts_type sts;

   assign csr_ready = 1'b1;

   dbrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dbrc_datapath #(
      .HALF_SECOND_TICKS (HALF_SECOND_TICKS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_button_sampled (req_button_sampled),
      .req_button_pressed (req_button_pressed),
      .req_reset_sampled  (req_reset_sampled),
      .req_reset_mv       (req_reset_mv),
      .rsp_led_on         (rsp_led_on),
      .rsp_rate_hz        (rsp_rate_hz),
      .rsp_pressed_stable (rsp_pressed_stable),
      .rsp_rate_changed   (rsp_rate_changed)
   );

endmodule

`default_nettype wire

[dv/debounced_blink_rate_controller_tb.sv]
// ----------------------------------------------------------------------------
// debounced_blink_rate_controller_tb
// Self-checking bench for the debounced blink rate controller.
//
// Ticks go in on the req channel and registers are written on the csr channel
// while the block is idle. A tick-level model of the debouncer, the rate
// clamp, the reset-voltage latch and the LED half-period counter predicts each
// rsp item, which is checked field by field in order. Directed ticks cover
// the corners; then random button sequences with bounce and voltage crossings
// run under several register settings, with random stalls on both sides and
// one long receiver hold-off.
// ----------------------------------------------------------------------------

module debounced_blink_rate_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dbrc_pkg::*;

   localparam int HALF_TICKS  = 500;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic              led_on;
      logic [RATE_W-1:0] rate_hz;
      logic              pressed_stable;
      logic              rate_changed;
   } tick_result_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_button_sampled = 1'b0;
   logic                  req_button_pressed = 1'b0;
   logic                  req_reset_sampled = 1'b0;
   logic [MV_W-1:0]       req_reset_mv = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_led_on;
   logic [RATE_W-1:0]     rsp_rate_hz;
   logic                  rsp_pressed_stable;
   logic                  rsp_rate_changed;

   // register copies
   logic [DEB_W-1:0]  deb_ticks = DEBOUNCE_RESET;
   logic [RATE_W-1:0] def_rate  = DEFAULT_RESET;
   logic [RATE_W-1:0] max_rate  = MAX_RESET;
   logic [RATE_W-1:0] step_rate = STEP_RESET;
   logic [MV_W-1:0]   thr_mv    = THRESHOLD_RESET;

   // blink state
   logic [RATE_W-1:0] rate_now = DEFAULT_RESET;
   logic              led_now = 1'b0;
   logic [HALF_W-1:0] hold_left = '0;
   logic [DEB_W-1:0]  ticks_since_change = '0;
   logic              button_stable = 1'b0;
   logic              reset_fired = 1'b0;

   tick_result_type pending_ticks[$];
   int              mismatch_count = 0;
   int              results_seen = 0;
   int              cycle_count = 0;
   bit              idling_on = 1'b1;
   int              rsp_hold_cycles = 0;

   // random button sequence state
   logic intended_level = 1'b0;
   int   level_hold = 0;

   debounced_blink_rate_controller dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_button_sampled (req_button_sampled),
      .req_button_pressed (req_button_pressed),
      .req_reset_sampled  (req_reset_sampled),
      .req_reset_mv       (req_reset_mv),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_led_on         (rsp_led_on),
      .rsp_rate_hz        (rsp_rate_hz),
      .rsp_pressed_stable (rsp_pressed_stable),
      .rsp_rate_changed   (rsp_rate_changed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("debounced_blink_rate_controller_tb NOT OK");
         $finish;
      end
   end

   function automatic logic [RATE_W-1:0] clamp_to_band(input int unsigned r);
      if (r < def_rate) r = 32'(def_rate);
      if (r > max_rate) r = 32'(max_rate);
      return RATE_W'(r);
   endfunction

   function automatic logic [HALF_W-1:0] half_period_reload(input logic [RATE_W-1:0] r);
      int unsigned h;
      h = (r == 0) ? HALF_TICKS : HALF_TICKS / r;
      if (h < 1) h = 1;
      return HALF_W'(h - 1);
   endfunction

   function automatic void advance_blink_state(input logic b_smp, input logic b_lvl,
                                               input logic r_smp,
                                               input logic [MV_W-1:0] mv);
      tick_result_type res;
      logic            changed;
      changed = 1'b0;
      if (ticks_since_change < deb_ticks) ticks_since_change++;
      if (b_smp && b_lvl != button_stable && ticks_since_change >= deb_ticks) begin
         button_stable = b_lvl;
         ticks_since_change = '0;
         if (b_lvl) begin
            rate_now = clamp_to_band(int'(rate_now) + int'(step_rate));
            changed = 1'b1;
         end
      end
      // reset wins over a press on the same tick
      if (r_smp) begin
         if (mv >= thr_mv) begin
            if (!reset_fired) begin
               rate_now = clamp_to_band(32'(def_rate));
               reset_fired = 1'b1;
               changed = 1'b1;
            end
         end else begin
            reset_fired = 1'b0;
         end
      end
      if (hold_left == 0) begin
         led_now = ~led_now;
         hold_left = half_period_reload(rate_now);
      end else begin
         hold_left--;
      end
      res.led_on = led_now;
      res.rate_hz = rate_now;
      res.pressed_stable = button_stable;
      res.rate_changed = changed;
      pending_ticks.push_back(res);
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("mismatch on result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      tick_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_ticks.size() == 0) begin
            flag_mismatch("item with nothing pending", 1, 0);
         end else begin
            want = pending_ticks.pop_front();
            if (rsp_led_on !== want.led_on)
               flag_mismatch("led_on", int'(rsp_led_on), int'(want.led_on));
            if (rsp_rate_hz !== want.rate_hz)
               flag_mismatch("rate_hz", int'(rsp_rate_hz), int'(want.rate_hz));
            if (rsp_pressed_stable !== want.pressed_stable)
               flag_mismatch("pressed_stable", int'(rsp_pressed_stable),
                             int'(want.pressed_stable));
            if (rsp_rate_changed !== want.rate_changed)
               flag_mismatch("rate_changed", int'(rsp_rate_changed),
                             int'(want.rate_changed));
         end
         results_seen++;
      end
   end

   // receiver: random stall bursts, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // valid stays high between back-to-back items; a pause drops it first
   task automatic send_tick(input logic b_smp, input logic b_lvl, input logic r_smp,
                            input logic [MV_W-1:0] mv);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_button_sampled <= b_smp;
      req_button_pressed <= b_lvl;
      req_reset_sampled <= r_smp;
      req_reset_mv <= mv;
      do @(posedge clock); while (!req_ready);
      advance_blink_state(b_smp, b_lvl, r_smp, mv);
   endtask

   task automatic set_config(input logic [DEB_W-1:0] deb, input logic [RATE_W-1:0] dflt,
                             input logic [RATE_W-1:0] mx, input logic [RATE_W-1:0] stp,
                             input logic [MV_W-1:0] thr);
      logic [CSR_IDX_W-1:0]  idx[5];
      logic [CSR_DATA_W-1:0] val[5];
      idx = '{CSR_DEBOUNCE, CSR_DEFAULT, CSR_MAX, CSR_STEP, CSR_THRESHOLD};
      val = '{CSR_DATA_W'(deb), CSR_DATA_W'(dflt), CSR_DATA_W'(mx), CSR_DATA_W'(stp),
              CSR_DATA_W'(thr)};
      req_valid <= 1'b0;
      while (pending_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            CSR_DEBOUNCE:  deb_ticks = val[i][DEB_W-1:0];
            CSR_DEFAULT:   def_rate = val[i][RATE_W-1:0];
            CSR_MAX:       max_rate = val[i][RATE_W-1:0];
            CSR_STEP:      step_rate = val[i][RATE_W-1:0];
            CSR_THRESHOLD: thr_mv = val[i][MV_W-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // button held at an intended level for at least the debounce time, with
   // bounce noise and dropped samples; voltage mostly near the threshold
   task automatic send_random_tick();
      logic b_smp;
      logic b_lvl;
      logic r_smp;
      int   v;
      if (level_hold <= 0) begin
         intended_level = ~intended_level;
         level_hold = int'(deb_ticks) + $urandom_range(1, 5);
      end
      level_hold--;
      b_smp = ($urandom_range(0, 9) < 8);
      b_lvl = ($urandom_range(0, 9) == 0) ? ~intended_level : intended_level;
      r_smp = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0)
         v = $urandom_range(0, 4095);
      else if ($urandom_range(0, 1) == 1)
         v = int'(thr_mv) + int'($urandom_range(0, 200));
      else
         v = int'(thr_mv) - int'($urandom_range(1, 200));
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      send_tick(b_smp, b_lvl, r_smp, MV_W'(v));
   endtask

   task automatic test_reset_voltage();
      send_tick(1'b0, 1'b0, 1'b0, 12'd0);
      // unsampled fields are ignored
      send_tick(1'b0, 1'b1, 1'b0, 12'd4095);
      // press too soon after reset is rejected
      send_tick(1'b1, 1'b1, 1'b0, 12'd0);
      send_tick(1'b0, 1'b0, 1'b1, 12'd4095);
      send_tick(1'b0, 1'b0, 1'b1, 12'd2500);
      send_tick(1'b0, 1'b0, 1'b1, 12'd2499);
      send_tick(1'b0, 1'b0, 1'b1, 12'd2500);
      send_tick(1'b0, 1'b0, 1'b1, 12'd0);
   endtask

   task automatic test_clamp_extremes();
      set_config(10'd0, 8'd1, 8'd255, 8'd255, 12'd0);
      send_tick(1'b1, 1'b1, 1'b0, 12'd0);
      send_tick(1'b1, 1'b0, 1'b0, 12'd0);
      // press and reset on one tick
      send_tick(1'b1, 1'b1, 1'b1, 12'd0);
      send_tick(1'b0, 1'b0, 1'b0, 12'd0);
   endtask

   task automatic test_default_above_max();
      set_config(10'd0, 8'd255, 8'd0, 8'd0, 12'd4095);
      send_tick(1'b1, 1'b0, 1'b0, 12'd0);
      // clamps to zero rate
      send_tick(1'b1, 1'b1, 1'b0, 12'd0);
      send_tick(1'b0, 1'b0, 1'b1, 12'd4094);
      send_tick(1'b0, 1'b0, 1'b1, 12'd4095);
      send_tick(1'b0, 1'b0, 1'b0, 12'd0);
   endtask

   task automatic test_long_debounce();
      set_config(10'd1023, DEFAULT_RESET, MAX_RESET, STEP_RESET, THRESHOLD_RESET);
      send_tick(1'b1, 1'b0, 1'b0, 12'd0);
      send_tick(1'b1, 1'b1, 1'b0, 12'd0);
   endtask

   task automatic test_pressure();
      set_config(10'd2, 8'd5, 8'd200, 8'd9, 12'd1800);
      rsp_hold_cycles = 300;
      repeat (12) send_random_tick();
   endtask

   task automatic test_random_traffic();
      logic [DEB_W-1:0]  deb;
      logic [RATE_W-1:0] dflt;
      logic [RATE_W-1:0] mx;
      logic [RATE_W-1:0] stp;
      for (int phase = 0; phase < 6; phase++) begin
         deb = ($urandom_range(0, 5) == 0) ? DEB_W'($urandom_range(20, 60))
                                           : DEB_W'($urandom_range(0, 6));
         dflt = RATE_W'($urandom_range(1, 40));
         mx = RATE_W'($urandom_range(32'(dflt), 255));
         if ($urandom_range(0, 3) == 0) begin
            dflt = RATE_W'($urandom_range(1, 255));
            mx = ($urandom_range(0, 2) == 0) ? 8'd0 : RATE_W'($urandom_range(1, 255));
         end
         stp = ($urandom_range(0, 3) == 0) ? RATE_W'($urandom_range(0, 255))
                                           : RATE_W'($urandom_range(0, 12));
         if (phase == 0)
            set_config(DEBOUNCE_RESET, DEFAULT_RESET, MAX_RESET, STEP_RESET,
                       THRESHOLD_RESET);
         else
            set_config(deb, dflt, mx, stp, MV_W'($urandom_range(0, 4095)));
         repeat (105) send_random_tick();
      end
   endtask

   task automatic test_steady_stream();
      set_config(10'd3, 8'd1, 8'd255, 8'd7, 12'd2000);
      idling_on = 1'b0;
      repeat (90) send_random_tick();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_voltage();
      test_clamp_extremes();
      test_default_above_max();
      test_long_debounce();
      test_pressure();
      test_random_traffic();
      test_steady_stream();
      req_valid <= 1'b0;
      while (pending_ticks.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0)
         $display("debounced_blink_rate_controller_tb OK");
      else
         $display("debounced_blink_rate_controller_tb NOT OK");
      $finish;
   end

endmodule

[debounced_blink_rate_controller.f]
rtl/dbrc_pkg.sv
rtl/dbrc_ctrl.sv
rtl/dbrc_datapath.sv
rtl/debounced_blink_rate_controller.sv
dv/debounced_blink_rate_controller_tb.sv
